### hw/rtl/mede_pkg.sv
// mede_pkg: shared constants, types and state codes of the mesh edge dedup indexer
// no dependencies

package mede_pkg;

    localparam int LANES     = 4;
    localparam int LANE_BITS = 2;

    localparam int DEF_MAX_EDGES   = 1024;
    localparam int DEF_VERTEX_BITS = 16;

    localparam int FIELD_VERTEX_BITS = 16;
    localparam int FIELD_ID_BITS     = 10;
    localparam int EDGES_PER_QUAD    = 4;

    localparam logic [1:0] LAST_SLOT = 2'(EDGES_PER_QUAD - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SEARCH,
        ST_RESOLVE
    } mede_state_t;

    typedef struct packed {
        logic                 hit;
        logic [LANE_BITS-1:0] lane;
    } mede_match_t;

endpackage

### hw/rtl/mede_lane.sv
// mede_lane: one bank of the edge table with its registered read and key compare
// depends on mede_pkg

module mede_lane
    import mede_pkg::*;
#(
    parameter int ROWS     = 256,
    parameter int ROW_BITS = 8,
    parameter int KEY_BITS = 32
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ROW_BITS-1:0] wr_row,
    input  logic [KEY_BITS-1:0] wr_key,
    input  logic [ROW_BITS-1:0] rd_row,
    input  logic [KEY_BITS-1:0] key,
    input  logic                entry_ok,
    output logic                hit
);

    logic [KEY_BITS-1:0] mem [ROWS];
    logic [KEY_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_key;
        end
        rdata_reg <= mem[rd_row];
    end

    assign hit = entry_ok && (rdata_reg == key);

endmodule

### hw/rtl/mede_merge.sv
// mede_merge: picks the lowest lane that matched, giving the first stored copy
// depends on mede_pkg

module mede_merge
    import mede_pkg::*;
(
    input  logic [LANES-1:0] lane_hit,
    output mede_match_t      match
);

    always_comb
    begin
        match.hit  = 1'b0;
        match.lane = '0;
        for (int l = LANES - 1; l >= 0; l--)
        begin
            if (lane_hit[l])
            begin
                match.hit  = 1'b1;
                match.lane = LANE_BITS'(l);
            end
        end
    end

endmodule

### hw/rtl/mesh_edge_dedup_indexer.sv
// mesh_edge_dedup_indexer: top level, quad edge lookup and append over banked lanes
// depends on mede_pkg, mede_lane, mede_merge
//
// input channel: one item is a quad of four vertex indices (vert_a..vert_d),
// taken when in_valid is high and in_stall is low; in_stall stays high while
// a quad is being worked on, so one quad is in the block at a time
// output channel: four result items per quad, slots 0 to 3, last_edge on slot 3,
// taken when out_valid is high and out_stall is low
// each edge goes through a setup step, then the table sweep of four banks read
// side by side one row a cycle through the registered bank reads, then a step
// to append and load the output register; the sweep stops early on a hit and
// is skipped on an empty table
// a quad also takes an accept step in the idle state before its edges
// while a result item is stalled the next edge waits in its append step
// reset empties the table (edge count to zero) and drops any item in flight

module mesh_edge_dedup_indexer
    import mede_pkg::*;
#(
    parameter int MAX_EDGES   = DEF_MAX_EDGES,
    parameter int VERTEX_BITS = DEF_VERTEX_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [FIELD_VERTEX_BITS-1:0] vert_a,
    input  logic [FIELD_VERTEX_BITS-1:0] vert_b,
    input  logic [FIELD_VERTEX_BITS-1:0] vert_c,
    input  logic [FIELD_VERTEX_BITS-1:0] vert_d,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   edge_slot,
    output logic [FIELD_ID_BITS-1:0]     edge_id,
    output logic [FIELD_VERTEX_BITS-1:0] low_vertex,
    output logic [FIELD_VERTEX_BITS-1:0] high_vertex,
    output logic                         is_new,
    output logic                         table_full,
    output logic                         last_edge
);

    localparam int VW   = (VERTEX_BITS < FIELD_VERTEX_BITS) ? VERTEX_BITS : FIELD_VERTEX_BITS;
    localparam int KW   = 2 * VW;
    localparam int IW   = $clog2(MAX_EDGES);
    localparam int CW   = $clog2(MAX_EDGES + 1);
    localparam int ROWS = (MAX_EDGES + LANES - 1) / LANES;
    localparam int RW   = (IW > LANE_BITS) ? (IW - LANE_BITS) : 1;

    mede_state_t state_reg, state_next;

    logic [VW-1:0] corner_reg [4];
    logic [VW-1:0] corner_next [4];
    logic [1:0]    slot_reg, slot_next;
    logic [CW-1:0] count_reg, count_next;
    logic [VW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic          issuing_reg, issuing_next;
    logic [RW-1:0] issue_row_reg, issue_row_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic          cmp_last_reg, cmp_last_next;
    logic [RW-1:0] cmp_row_reg, cmp_row_next;
    logic          found_reg, found_next;
    logic [IW-1:0] id_reg, id_next;

    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               o_slot_reg, o_slot_next;
    logic [FIELD_ID_BITS-1:0] o_id_reg, o_id_next;
    logic [VW-1:0]            o_lo_reg, o_lo_next, o_hi_reg, o_hi_next;
    logic                     o_new_reg, o_new_next;
    logic                     o_full_reg, o_full_next;

    logic [VW-1:0]    p, q;
    logic [KW-1:0]    key;
    logic [CW:0]      next_base, cmp_base;
    logic [LANES-1:0] lane_hit, lane_ok, lane_wr;
    logic [IW-1:0]    wr_idx;
    logic             wr_en;
    mede_match_t      match;

    assign key    = {lo_reg, hi_reg};
    assign wr_idx = IW'(count_reg);
    assign next_base = ((CW + 1)'(issue_row_reg) + (CW + 1)'(1)) << LANE_BITS;
    assign cmp_base  = (CW + 1)'(cmp_row_reg) << LANE_BITS;

    always_comb
    begin
        p = corner_reg[slot_reg + 2'd1];
        q = corner_reg[slot_reg + 2'd2];
    end

    genvar gl;
    generate
        for (gl = 0; gl < LANES; gl++)
        begin : g_lane
            assign lane_ok[gl] = (cmp_base + (CW + 1)'(gl)) < (CW + 1)'(count_reg);
            assign lane_wr[gl] = wr_en && (wr_idx[LANE_BITS-1:0] == LANE_BITS'(gl));

            mede_lane #(
                .ROWS     (ROWS),
                .ROW_BITS (RW),
                .KEY_BITS (KW)
            ) u_lane (
                .clk      (clk),
                .wr_en    (lane_wr[gl]),
                .wr_row   (RW'(wr_idx >> LANE_BITS)),
                .wr_key   (key),
                .rd_row   (issue_row_reg),
                .key      (key),
                .entry_ok (lane_ok[gl]),
                .hit      (lane_hit[gl])
            );
        end
    endgenerate

    mede_merge u_merge (
        .lane_hit (lane_hit),
        .match    (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issuing_reg   <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issuing_reg   <= issuing_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        corner_reg    <= corner_next;
        slot_reg      <= slot_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        issue_row_reg <= issue_row_next;
        cmp_last_reg  <= cmp_last_next;
        cmp_row_reg   <= cmp_row_next;
        found_reg     <= found_next;
        id_reg        <= id_next;
        o_slot_reg    <= o_slot_next;
        o_id_reg      <= o_id_next;
        o_lo_reg      <= o_lo_next;
        o_hi_reg      <= o_hi_next;
        o_new_reg     <= o_new_next;
        o_full_reg    <= o_full_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        corner_next    = corner_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        issuing_next   = issuing_reg;
        issue_row_next = issue_row_reg;
        cmp_valid_next = 1'b0;
        cmp_last_next  = cmp_last_reg;
        cmp_row_next   = cmp_row_reg;
        found_next     = found_reg;
        id_next        = id_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_slot_next    = o_slot_reg;
        o_id_next      = o_id_reg;
        o_lo_next      = o_lo_reg;
        o_hi_next      = o_hi_reg;
        o_new_next     = o_new_reg;
        o_full_next    = o_full_reg;
        wr_en          = 1'b0;
        in_stall       = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    corner_next[0] = VW'(vert_a);
                    corner_next[1] = VW'(vert_b);
                    corner_next[2] = VW'(vert_c);
                    corner_next[3] = VW'(vert_d);
                    slot_next      = 2'd0;
                    state_next     = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                lo_next        = (p < q) ? p : q;
                hi_next        = (p < q) ? q : p;
                issue_row_next = '0;
                found_next     = 1'b0;
                if (count_reg == '0)
                begin
                    issuing_next = 1'b0;
                    state_next   = ST_RESOLVE;
                end
                else
                begin
                    issuing_next = 1'b1;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (issuing_reg)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_row_next   = issue_row_reg;
                    cmp_last_next  = (next_base >= (CW + 1)'(count_reg));
                    if (next_base >= (CW + 1)'(count_reg))
                    begin
                        issuing_next = 1'b0;
                    end
                    else
                    begin
                        issue_row_next = issue_row_reg + RW'(1);
                    end
                end
                if (cmp_valid_reg && match.hit)
                begin
                    found_next     = 1'b1;
                    id_next        = IW'({cmp_row_reg, match.lane});
                    issuing_next   = 1'b0;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_RESOLVE;
                end
                else if (cmp_valid_reg && cmp_last_reg)
                begin
                    found_next     = 1'b0;
                    issuing_next   = 1'b0;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    o_slot_next    = slot_reg;
                    o_lo_next      = lo_reg;
                    o_hi_next      = hi_reg;
                    o_new_next     = 1'b0;
                    o_full_next    = 1'b0;
                    if (found_reg)
                    begin
                        o_id_next = FIELD_ID_BITS'(id_reg);
                    end
                    else if ((CW + 1)'(count_reg) < (CW + 1)'(MAX_EDGES))
                    begin
                        o_id_next  = FIELD_ID_BITS'(count_reg);
                        o_new_next = 1'b1;
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        o_id_next   = '0;
                        o_full_next = 1'b1;
                    end
                    slot_next  = slot_reg + 2'd1;
                    state_next = (slot_reg == LAST_SLOT) ? ST_IDLE : ST_SETUP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign edge_slot   = o_slot_reg;
    assign edge_id     = o_id_reg;
    assign low_vertex  = FIELD_VERTEX_BITS'(o_lo_reg);
    assign high_vertex = FIELD_VERTEX_BITS'(o_hi_reg);
    assign is_new      = o_new_reg;
    assign table_full  = o_full_reg;
    assign last_edge   = (o_slot_reg == LAST_SLOT);

endmodule

### hw/rtl/mede_checker.sv
// mede_checker: port-level assertions for the mesh edge dedup indexer, with its bind
// depends on mede_pkg and mesh_edge_dedup_indexer

module mede_checker
    import mede_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] edge_slot,
    input logic [9:0] edge_id,
    input logic       is_new,
    input logic       table_full,
    input logic       last_edge
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(edge_slot) && $stable(edge_id))
        else $error("stalled output item changed");

    a_full_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> !is_new && (edge_id == 10'd0))
        else $error("full table item carries new flag or index");

    a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_edge == (edge_slot == LAST_SLOT)))
        else $error("last marker not on final slot");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("new quad taken while one is in work");

endmodule

bind mesh_edge_dedup_indexer mede_checker u_mede_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_slot  (edge_slot),
    .edge_id    (edge_id),
    .is_new     (is_new),
    .table_full (table_full),
    .last_edge  (last_edge)
);
